[src/rthsv_pkg.sv]
// ---------------------------------------------------------------------------
// rthsv_pkg
// types and constants shared by the rgb to hsv pixel converter
// ---------------------------------------------------------------------------
package rthsv_pkg;

    localparam int CH_W   = 8;
    localparam int DIFF_W = CH_W + 1;
    localparam int NUM_W  = 12;
    localparam int REM_W  = 19;
    localparam int DEN_W  = 11;
    localparam int QUO_W  = 8;

    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0]          mx;
        logic [CH_W-1:0]          delta;
        logic [1:0]               sector;
        logic signed [DIFF_W-1:0] diff;
    } cls_t;

endpackage

[src/rthsv_front.sv]
// ---------------------------------------------------------------------------
// rthsv_front
// takes pixels in and finds maximum, spread, dominant sector and difference
// ---------------------------------------------------------------------------
module rthsv_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [rthsv_pkg::CH_W-1:0]    red,
    input  logic [rthsv_pkg::CH_W-1:0]    green,
    input  logic [rthsv_pkg::CH_W-1:0]    blue,
    output logic                          cls_valid,
    input  logic                          cls_ready,
    output rthsv_pkg::cls_t               cls
);

    logic                       valid_reg;
    logic                       valid_next;
    rthsv_pkg::cls_t            cls_reg;
    rthsv_pkg::cls_t            cls_next;
    logic                       take;
    logic                       give;
    logic [rthsv_pkg::CH_W-1:0] mn;

    assign give = valid_reg && cls_ready;
    assign full = valid_reg && !cls_ready;
    assign take = push && !full;

    always_comb
    begin
        cls_next = cls_reg;
        // ties go to red, then green
        if (red >= green && red >= blue)
        begin
            cls_next.mx     = red;
            cls_next.sector = rthsv_pkg::SECTOR_RED;
            cls_next.diff   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            cls_next.mx     = green;
            cls_next.sector = rthsv_pkg::SECTOR_GREEN;
            cls_next.diff   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            cls_next.mx     = blue;
            cls_next.sector = rthsv_pkg::SECTOR_BLUE;
            cls_next.diff   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        cls_next.delta = cls_next.mx - mn;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (give)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cls_reg <= cls_next;
        end
    end

    assign cls_valid = valid_reg;
    assign cls       = cls_reg;

endmodule

[src/rthsv_fifo.sv]
// ---------------------------------------------------------------------------
// rthsv_fifo
// short queue of classified pixels between the front and the divider
// ---------------------------------------------------------------------------
module rthsv_fifo
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rthsv_pkg::cls_t wr_data,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rthsv_pkg::cls_t rd_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);

    rthsv_pkg::cls_t  mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             wr_en;
    logic             rd_en;

    assign wr_ready = (cnt_reg != CNT_W'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign wr_en    = wr_valid && wr_ready;
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_lost: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue lost a transfer");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && !wr_en |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue repeated a transfer");

endmodule

[src/rthsv_back.sv]
// ---------------------------------------------------------------------------
// rthsv_back
// forms the saturation and hue fractions and divides them, one bit a stage
// ---------------------------------------------------------------------------
module rthsv_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rthsv_pkg::cls_t               in_data,
    output logic                          empty,
    input  logic                          pop,
    output logic [rthsv_pkg::QUO_W-1:0]   hue,
    output logic [rthsv_pkg::QUO_W-1:0]   saturation,
    output logic [rthsv_pkg::CH_W-1:0]    brightness
);

    localparam int QW = rthsv_pkg::QUO_W;
    localparam int RW = rthsv_pkg::REM_W;
    localparam int DW = rthsv_pkg::DEN_W;
    localparam int NW = rthsv_pkg::NUM_W;

    // stage 0 holds the fractions, stage k settles quotient bit QW-k
    logic                          valid_reg [QW+1];
    logic [RW-1:0]                 rem_s_reg [QW+1];
    logic [RW-1:0]                 rem_h_reg [QW+1];
    logic [DW-1:0]                 den_s_reg [QW+1];
    logic [DW-1:0]                 den_h_reg [QW+1];
    logic [QW-1:0]                 quo_s_reg [QW+1];
    logic [QW-1:0]                 quo_h_reg [QW+1];
    logic [rthsv_pkg::CH_W-1:0]    mx_reg    [QW+1];
    logic                          adv       [QW+2];

    logic signed [NW-1:0] num;
    logic [NW-1:0]        d_ext;
    logic [RW-1:0]        hue_n;
    logic [RW-1:0]        sat_n;
    logic [DW-1:0]        hue_d;
    logic [DW-1:0]        sat_d;

    always_comb
    begin
        adv[QW+1] = pop;
        for (int k = QW; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
    end

    assign in_ready = adv[0];

    always_comb
    begin
        d_ext = NW'(in_data.delta);
        case (in_data.sector)
            rthsv_pkg::SECTOR_RED:   num = NW'(in_data.diff);
            rthsv_pkg::SECTOR_GREEN: num = $signed(d_ext << 1) + NW'(in_data.diff);
            default:                 num = $signed(d_ext << 2) + NW'(in_data.diff);
        endcase
        if (num < 0)
        begin
            num = num + $signed((d_ext << 2) + (d_ext << 1));
        end
        // grey and black give zero over one
        if (in_data.delta == '0)
        begin
            hue_n = '0;
            sat_n = '0;
            hue_d = DW'(1);
            sat_d = DW'(1);
        end
        else
        begin
            hue_n = (RW'(unsigned'(num)) << 8) - RW'(unsigned'(num))
                    + RW'(in_data.delta) + (RW'(in_data.delta) << 1);
            sat_n = (RW'(in_data.delta) << 9) - (RW'(in_data.delta) << 1)
                    + RW'(in_data.mx);
            hue_d = (DW'(in_data.delta) << 2) + (DW'(in_data.delta) << 1);
            sat_d = DW'(in_data.mx) << 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k <= QW; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            rem_s_reg[0] <= sat_n;
            rem_h_reg[0] <= hue_n;
            den_s_reg[0] <= sat_d;
            den_h_reg[0] <= hue_d;
            quo_s_reg[0] <= '0;
            quo_h_reg[0] <= '0;
            mx_reg[0]    <= in_data.mx;
        end
        for (int k = 1; k <= QW; k++)
        begin
            if (adv[k])
            begin
                den_s_reg[k] <= den_s_reg[k-1];
                den_h_reg[k] <= den_h_reg[k-1];
                mx_reg[k]    <= mx_reg[k-1];
                if (rem_s_reg[k-1] >= (RW'(den_s_reg[k-1]) << (QW - k)))
                begin
                    rem_s_reg[k] <= rem_s_reg[k-1] - (RW'(den_s_reg[k-1]) << (QW - k));
                    quo_s_reg[k] <= quo_s_reg[k-1] | (QW'(1) << (QW - k));
                end
                else
                begin
                    rem_s_reg[k] <= rem_s_reg[k-1];
                    quo_s_reg[k] <= quo_s_reg[k-1];
                end
                if (rem_h_reg[k-1] >= (RW'(den_h_reg[k-1]) << (QW - k)))
                begin
                    rem_h_reg[k] <= rem_h_reg[k-1] - (RW'(den_h_reg[k-1]) << (QW - k));
                    quo_h_reg[k] <= quo_h_reg[k-1] | (QW'(1) << (QW - k));
                end
                else
                begin
                    rem_h_reg[k] <= rem_h_reg[k-1];
                    quo_h_reg[k] <= quo_h_reg[k-1];
                end
            end
        end
    end

    assign empty      = !valid_reg[QW];
    assign hue        = quo_h_reg[QW];
    assign saturation = quo_s_reg[QW];
    assign brightness = mx_reg[QW];

    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QW] |-> rem_s_reg[QW] < RW'(den_s_reg[QW]))
        else $error("saturation quotient overflowed eight bits");

    a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QW] |-> rem_h_reg[QW] < RW'(den_h_reg[QW]))
        else $error("hue quotient overflowed eight bits");

    a_sat_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QW] && mx_reg[QW] == '0 |-> quo_s_reg[QW] == '0)
        else $error("black pixel with saturation");

endmodule

[src/rgb_to_hsv_pixel.sv]
// path: front register, then the queue, then every divider stage, then the output ports
// throughput: one pixel per cycle while pop is high; each stage then takes a pixel each cycle
// the result stays on the ports until popped; stalls back up through the queue
// reset: asynchronous, active low, empties every stage and the queue
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit rgb to 8-bit hsv converter with queue-style ports on both sides
// ---------------------------------------------------------------------------
module rgb_to_hsv_pixel
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [rthsv_pkg::CH_W-1:0]  red,
    input  logic [rthsv_pkg::CH_W-1:0]  green,
    input  logic [rthsv_pkg::CH_W-1:0]  blue,
    output logic                        empty,
    input  logic                        pop,
    output logic [rthsv_pkg::QUO_W-1:0] hue,
    output logic [rthsv_pkg::QUO_W-1:0] saturation,
    output logic [rthsv_pkg::CH_W-1:0]  brightness
);

    logic            f_valid;
    logic            f_ready;
    rthsv_pkg::cls_t f_data;
    logic            q_valid;
    logic            q_ready;
    rthsv_pkg::cls_t q_data;

    rthsv_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .cls_valid (f_valid),
        .cls_ready (f_ready),
        .cls       (f_data)
    );

    rthsv_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_data),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    rthsv_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_data    (q_data),
        .empty      (empty),
        .pop        (pop),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

endmodule

[dv/rgb_to_hsv_pixel_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb_to_hsv_pixel_tb
// pushes directed and random pixels through the converter, predicts hue,
// saturation and brightness in exact integer form and checks each popped
// result in order, with random idling on both sides
// ---------------------------------------------------------------------------
module rgb_to_hsv_pixel_tb;

    typedef struct {
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] bright;
    } hsv_t;

    int errors = 0;

    task automatic report_mismatch(input string msg);
        begin
            $display("mismatch: %s", msg);
            errors++;
        end
    endtask

    class hsv_scoreboard;
        hsv_t pending[$];

        function hsv_t convert(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            hsv_t res;
            int mx;
            int mn;
            int dl;
            int num;
            logic [1:0] sector;
            begin
                mx = int'(r);
                sector = rthsv_pkg::SECTOR_RED;
                if (int'(g) > mx)
                begin
                    mx = int'(g);
                    sector = rthsv_pkg::SECTOR_GREEN;
                end
                if (int'(b) > mx)
                begin
                    mx = int'(b);
                    sector = rthsv_pkg::SECTOR_BLUE;
                end
                mn = int'(r);
                if (int'(g) < mn) mn = int'(g);
                if (int'(b) < mn) mn = int'(b);
                dl = mx - mn;
                res.hue = '0;
                res.sat = '0;
                res.bright = 8'(mx);
                if (mx != 0 && dl != 0)
                begin
                    res.sat = 8'((510 * dl + mx) / (2 * mx));
                    case (sector)
                        rthsv_pkg::SECTOR_RED:   num = int'(g) - int'(b);
                        rthsv_pkg::SECTOR_GREEN: num = 2 * dl + int'(b) - int'(r);
                        default:                 num = 4 * dl + int'(r) - int'(g);
                    endcase
                    if (num < 0) num += 6 * dl;
                    res.hue = 8'((255 * num + 3 * dl) / (6 * dl));
                end
                return res;
            end
        endfunction

        function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
            pending.insert(pending.size(), convert(r, g, b));
        endfunction

        task check_result(logic [7:0] h, logic [7:0] s, logic [7:0] v);
            hsv_t exp;
            begin
                if (pending.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %0d/%0d/%0d", h, s, v));
                    return;
                end
                exp = pending.pop_front();
                if (h !== exp.hue)
                    report_mismatch($sformatf("hue %0d, expected %0d", h, exp.hue));
                if (s !== exp.sat)
                    report_mismatch($sformatf("saturation %0d, expected %0d", s, exp.sat));
                if (v !== exp.bright)
                    report_mismatch($sformatf("brightness %0d, expected %0d", v, exp.bright));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic [7:0] red = '0;
    logic [7:0] green = '0;
    logic [7:0] blue = '0;
    logic full;
    logic empty;
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;

    int send_idle_pct = 33;
    int recv_idle_pct = 50;

    hsv_scoreboard sb = new();

    rgb_to_hsv_pixel DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .red(red),
        .green(green),
        .blue(blue),
        .empty(empty),
        .pop(pop),
        .hue(hue),
        .saturation(saturation),
        .brightness(brightness)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver: pop at random, check every transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_result(hue, saturation, brightness);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // push is left high after a transfer; the next call drops it when it idles, or the caller drops it
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                push <= 1'b0;
                @(posedge clk);
            end
            push <= 1'b1;
            red <= r;
            green <= g;
            blue <= b;
            @(posedge clk);
            while (full)
                @(posedge clk);
            sb.note_pixel(r, g, b);
        end
    endtask

    task automatic send_random(input int count);
        logic [7:0] c[3];
        int m;
        begin
            repeat (count)
            begin
                foreach (c[i]) c[i] = 8'($urandom());
                m = $urandom_range(9);
                // bias towards ties, grey and zero channels so the sector rules get exercised
                if (m == 0) c[1] = c[0];
                else if (m == 1) c[2] = c[1];
                else if (m == 2) c[2] = c[0];
                else if (m == 3)
                begin
                    c[1] = c[0];
                    c[2] = c[0];
                end
                else if (m == 4) c[$urandom_range(2)] = 8'd0;
                send_pixel(c[0], c[1], c[2]);
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // black, grey, white, primaries, ties and wrap-around
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd255);
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd1, 8'd1, 8'd0);
        send_pixel(8'd200, 8'd100, 8'd150);
        send_pixel(8'd100, 8'd200, 8'd150);
        send_pixel(8'd150, 8'd100, 8'd200);
        send_pixel(8'd170, 8'd85, 8'd0);
        send_random(650);
        send_idle_pct = 50;
        recv_idle_pct = 33;
        send_random(650);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(650);
        push <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
src/rthsv_pkg.sv
src/rthsv_front.sv
src/rthsv_fifo.sv
src/rthsv_back.sv
src/rgb_to_hsv_pixel.sv
dv/rgb_to_hsv_pixel_tb.sv
